// ===== sv/assert_macros.svh =====
// Assertion macros shared by the frame encoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define JDFE_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define JDFE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/jdfe_pkg.sv =====
// Types and constants shared by the joystick drive frame encoder.
package jdfe_pkg;

    localparam int SAMPLE_W  = 10;
    localparam int DEAD_W    = 9;
    localparam int RANGE_W   = 10;
    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 10;
    localparam int PROD_W    = 21;
    localparam int SCALED_W  = 12;
    localparam int MIX_W     = 13;
    localparam int WORD_W    = 32;
    localparam int IDX_W     = 4;

    localparam int FRAME_BYTES = 12;

    localparam logic [SAMPLE_W-1:0] AXIS_CENTRE = 10'd512;
    localparam logic [11:0]         AXIS_SPAN   = 12'd1023;
    localparam logic [11:0]         AXIS_SPAN2  = 12'd2046;

    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_BAND     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_RANGE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FORWARD_RANGE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_BYTE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CRC_POLY      = 3'd4;

    localparam logic [DEAD_W-1:0]  RST_DEAD_BAND     = 9'd45;
    localparam logic [RANGE_W-1:0] RST_TURN_RANGE    = 10'd100;
    localparam logic [RANGE_W-1:0] RST_FORWARD_RANGE = 10'd150;
    localparam logic [BYTE_W-1:0]  RST_SYNC_BYTE     = 8'hAA;
    localparam logic [BYTE_W-1:0]  RST_CRC_POLY      = 8'h07;

    localparam logic [1:0] DRV_STOP     = 2'd0;
    localparam logic [1:0] DRV_AUTO     = 2'd1;
    localparam logic [1:0] DRV_MANUAL   = 2'd2;
    localparam logic [1:0] LIGHT_AUTO   = 2'd0;
    localparam logic [1:0] LIGHT_RED    = 2'd1;
    localparam logic [1:0] LIGHT_DISCO  = 2'd2;

    localparam logic [IDX_W-1:0] BYTE_SYNC   = 4'd0;
    localparam logic [IDX_W-1:0] BYTE_DRIVE  = 4'd1;
    localparam logic [IDX_W-1:0] BYTE_LIGHT  = 4'd2;
    localparam logic [IDX_W-1:0] BYTE_LEFT0  = 4'd3;
    localparam logic [IDX_W-1:0] BYTE_LEFT3  = 4'd6;
    localparam logic [IDX_W-1:0] BYTE_RIGHT0 = 4'd7;
    localparam logic [IDX_W-1:0] BYTE_RIGHT3 = 4'd10;
    localparam logic [IDX_W-1:0] BYTE_CRC    = 4'd11;

    typedef struct packed {
        logic [DEAD_W-1:0]  dead_band;
        logic [RANGE_W-1:0] turn_range;
        logic [RANGE_W-1:0] forward_range;
        logic [BYTE_W-1:0]  sync_byte;
        logic [BYTE_W-1:0]  crc_poly;
    } t_cfg;

    typedef struct packed {
        logic [1:0] drive;
        logic [1:0] light;
    } t_modes;

    typedef struct packed {
        t_modes                   modes;
        logic signed [MIX_W-1:0]  left;
        logic signed [MIX_W-1:0]  right;
    } t_frame;

endpackage

// ===== sv/jdfe_pipe.sv =====
// Four-stage axis pipeline: deadband, multiply, divide by 1023, mix.
`include "assert_macros.svh"

module jdfe_pipe (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  jdfe_pkg::t_cfg                 i_cfg,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [jdfe_pkg::SAMPLE_W-1:0]  i_x_sample,
    input  logic [jdfe_pkg::SAMPLE_W-1:0]  i_y_sample,
    input  jdfe_pkg::t_modes               i_modes,
    output logic                           o_valid,
    input  logic                           i_ready,
    output jdfe_pkg::t_frame               o_frame
);

    function automatic logic [jdfe_pkg::SAMPLE_W-1:0] deadband(
        input logic [jdfe_pkg::SAMPLE_W-1:0] s,
        input logic [jdfe_pkg::DEAD_W-1:0]   db
    );
        logic signed [jdfe_pkg::SAMPLE_W:0] v;
        logic        [jdfe_pkg::SAMPLE_W-1:0] mag;
        begin
            v   = $signed({1'b0, s}) - $signed({1'b0, jdfe_pkg::AXIS_CENTRE});
            mag = v[jdfe_pkg::SAMPLE_W] ? jdfe_pkg::SAMPLE_W'(-v) : v[jdfe_pkg::SAMPLE_W-1:0];
            deadband = (mag < {1'b0, db}) ? jdfe_pkg::AXIS_CENTRE : s;
        end
    endfunction

    // n = 1024*a + b = 1023*a + (a + b), and a + b stays below three times 1023.
    function automatic logic signed [jdfe_pkg::SCALED_W-1:0] div_scale(
        input logic [jdfe_pkg::PROD_W-1:0]  n,
        input logic [jdfe_pkg::RANGE_W-1:0] r
    );
        logic [10:0] a;
        logic [11:0] t;
        logic [10:0] q;
        begin
            a = n[jdfe_pkg::PROD_W-1:10];
            t = {1'b0, a} + {2'b00, n[9:0]};
            if (t >= jdfe_pkg::AXIS_SPAN2) begin
                q = a + 11'd2;
            end else if (t >= jdfe_pkg::AXIS_SPAN) begin
                q = a + 11'd1;
            end else begin
                q = a;
            end
            div_scale = $signed({1'b0, q}) - $signed({2'b00, r});
        end
    endfunction

    logic en1, en2, en3, en4;

    logic                                  r_v1, r_v2, r_v3, r_v4;
    logic [jdfe_pkg::SAMPLE_W-1:0]         r_x_u, r_y_u;
    logic [jdfe_pkg::PROD_W-1:0]           r_x_n, r_y_n;
    logic signed [jdfe_pkg::SCALED_W-1:0]  r_turn, r_fwd;
    jdfe_pkg::t_modes                      r_m1, r_m2, r_m3;
    jdfe_pkg::t_frame                      r_frame;

    assign en4 = !r_v4 || i_ready;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign o_ready = en1;
    assign o_valid = r_v4;
    assign o_frame = r_frame;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_x_u <= deadband(i_x_sample, i_cfg.dead_band);
            r_y_u <= deadband(i_y_sample, i_cfg.dead_band);
            r_m1  <= i_modes;
        end
        if (en2) begin
            r_x_n <= jdfe_pkg::PROD_W'(r_x_u)
                   * jdfe_pkg::PROD_W'({i_cfg.turn_range, 1'b0});
            r_y_n <= jdfe_pkg::PROD_W'(r_y_u)
                   * jdfe_pkg::PROD_W'({i_cfg.forward_range, 1'b0});
            r_m2  <= r_m1;
        end
        if (en3) begin
            r_turn <= div_scale(r_x_n, i_cfg.turn_range);
            r_fwd  <= div_scale(r_y_n, i_cfg.forward_range);
            r_m3   <= r_m2;
        end
        if (en4) begin
            r_frame.modes <= r_m3;
            r_frame.left  <= $signed({r_fwd[jdfe_pkg::SCALED_W-1], r_fwd})
                           + $signed({r_turn[jdfe_pkg::SCALED_W-1], r_turn});
            r_frame.right <= $signed({r_fwd[jdfe_pkg::SCALED_W-1], r_fwd})
                           - $signed({r_turn[jdfe_pkg::SCALED_W-1], r_turn});
        end
    end

    `JDFE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, r_v4 && !i_ready, r_v4 && $stable(r_frame))
    `JDFE_ASSERT_NEXT(a_s3_hold, i_clk, i_rst_n, r_v3 && !en4, r_v3 && $stable(r_turn))

endmodule

// ===== sv/jdfe_ser.sv =====
// Frame serializer: sends twelve bytes per frame and builds the CRC as bytes leave.
`include "assert_macros.svh"

module jdfe_ser (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  jdfe_pkg::t_cfg               i_cfg,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  jdfe_pkg::t_frame             i_frame,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [jdfe_pkg::BYTE_W-1:0]  o_frame_byte,
    output logic                         o_last_byte
);

    function automatic logic [jdfe_pkg::BYTE_W-1:0] crc_byte(
        input logic [jdfe_pkg::BYTE_W-1:0] c_in,
        input logic [jdfe_pkg::BYTE_W-1:0] poly
    );
        logic [jdfe_pkg::BYTE_W-1:0] c;
        begin
            c = c_in;
            for (int b = 0; b < 8; b++) begin
                c = c[7] ? ({c[6:0], 1'b0} ^ poly) : {c[6:0], 1'b0};
            end
            crc_byte = c;
        end
    endfunction

    logic                          r_busy;
    logic [jdfe_pkg::IDX_W-1:0]    r_idx;
    logic [jdfe_pkg::BYTE_W-1:0]   r_crc;
    jdfe_pkg::t_frame              r_frame;

    logic                          load;
    logic                          take;
    logic                          last;
    logic [jdfe_pkg::IDX_W-1:0]    sh;
    logic [jdfe_pkg::WORD_W-1:0]   word;
    logic [jdfe_pkg::BYTE_W-1:0]   sel;

    assign last = (r_idx == jdfe_pkg::BYTE_CRC);
    assign take = r_busy && i_ready;
    assign load = i_valid && (!r_busy || (i_ready && last));
    assign o_ready = load;
    assign o_valid = r_busy;
    assign o_last_byte = last;
    assign o_frame_byte = sel;

    always_comb begin
        sh   = '0;
        word = '0;
        sel  = '0;
        case (r_idx) inside
            jdfe_pkg::BYTE_SYNC:  sel = i_cfg.sync_byte;
            jdfe_pkg::BYTE_DRIVE: sel = {6'b0, r_frame.modes.drive};
            jdfe_pkg::BYTE_LIGHT: sel = {6'b0, r_frame.modes.light};
            [jdfe_pkg::BYTE_LEFT0:jdfe_pkg::BYTE_LEFT3]: begin
                sh   = r_idx - jdfe_pkg::BYTE_LEFT0;
                word = {{(jdfe_pkg::WORD_W-jdfe_pkg::MIX_W){r_frame.left[jdfe_pkg::MIX_W-1]}},
                        r_frame.left};
                sel  = word[{sh[1:0], 3'b000} +: jdfe_pkg::BYTE_W];
            end
            [jdfe_pkg::BYTE_RIGHT0:jdfe_pkg::BYTE_RIGHT3]: begin
                sh   = r_idx - jdfe_pkg::BYTE_RIGHT0;
                word = {{(jdfe_pkg::WORD_W-jdfe_pkg::MIX_W){r_frame.right[jdfe_pkg::MIX_W-1]}},
                        r_frame.right};
                sel  = word[{sh[1:0], 3'b000} +: jdfe_pkg::BYTE_W];
            end
            jdfe_pkg::BYTE_CRC:   sel = r_crc;
            default:              sel = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= jdfe_pkg::BYTE_SYNC;
            r_crc  <= '0;
        end else if (load) begin
            r_busy <= 1'b1;
            r_idx  <= jdfe_pkg::BYTE_SYNC;
            r_crc  <= '0;
        end else if (take) begin
            if (last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 1'b1;
                r_crc <= crc_byte(r_crc ^ sel, i_cfg.crc_poly);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_frame <= i_frame;
        end
    end

    `JDFE_ASSERT_NEXT(a_frame_goes_on, i_clk, i_rst_n, take && !last, o_valid)
    `JDFE_ASSERT_NEXT(a_idx_steps, i_clk, i_rst_n, take && !last, r_idx == $past(r_idx) + 1'b1)
    `JDFE_ASSERT_SAME(a_load_slot, i_clk, i_rst_n, load && r_busy, take && last)

endmodule

// ===== sv/joystick_drive_frame_encoder_unit.sv =====
// Top level of the joystick drive frame encoder with its configuration registers.
// A frame's first byte is valid once its samples pass the pipeline stages and load
// the serializer, which sends one byte per cycle while i_ready is high.
// The four-stage pipeline and the serializer together hold up to five sample sets.
// Reset is synchronous and active low; it empties the pipeline and serializer and
// restores every configuration register to its default value.
module joystick_drive_frame_encoder_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [jdfe_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [jdfe_pkg::CFG_DAT_W-1:0]   i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [jdfe_pkg::SAMPLE_W-1:0]    i_x_sample,
    input  logic [jdfe_pkg::SAMPLE_W-1:0]    i_y_sample,
    input  logic                             i_manual_button,
    input  logic                             i_auto_button,
    input  logic                             i_disco_button,
    input  logic                             i_red_button,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [jdfe_pkg::BYTE_W-1:0]      o_frame_byte,
    output logic                             o_last_byte
);

    jdfe_pkg::t_cfg    r_cfg;
    jdfe_pkg::t_modes  modes;
    jdfe_pkg::t_frame  frame;
    logic              frame_valid;
    logic              frame_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dead_band     <= jdfe_pkg::RST_DEAD_BAND;
            r_cfg.turn_range    <= jdfe_pkg::RST_TURN_RANGE;
            r_cfg.forward_range <= jdfe_pkg::RST_FORWARD_RANGE;
            r_cfg.sync_byte     <= jdfe_pkg::RST_SYNC_BYTE;
            r_cfg.crc_poly      <= jdfe_pkg::RST_CRC_POLY;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                jdfe_pkg::CFG_DEAD_BAND:     r_cfg.dead_band     <= i_cfg_data[8:0];
                jdfe_pkg::CFG_TURN_RANGE:    r_cfg.turn_range    <= i_cfg_data;
                jdfe_pkg::CFG_FORWARD_RANGE: r_cfg.forward_range <= i_cfg_data;
                jdfe_pkg::CFG_SYNC_BYTE:     r_cfg.sync_byte     <= i_cfg_data[7:0];
                jdfe_pkg::CFG_CRC_POLY:      r_cfg.crc_poly      <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (!i_manual_button) begin
            modes.drive = jdfe_pkg::DRV_MANUAL;
        end else if (!i_auto_button) begin
            modes.drive = jdfe_pkg::DRV_AUTO;
        end else begin
            modes.drive = jdfe_pkg::DRV_STOP;
        end
        if (!i_disco_button) begin
            modes.light = jdfe_pkg::LIGHT_DISCO;
        end else if (!i_red_button) begin
            modes.light = jdfe_pkg::LIGHT_RED;
        end else begin
            modes.light = jdfe_pkg::LIGHT_AUTO;
        end
    end

    jdfe_pipe u_pipe (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_x_sample (i_x_sample),
        .i_y_sample (i_y_sample),
        .i_modes    (modes),
        .o_valid    (frame_valid),
        .i_ready    (frame_ready),
        .o_frame    (frame)
    );

    jdfe_ser u_ser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (frame_valid),
        .o_ready      (frame_ready),
        .i_frame      (frame),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_frame_byte (o_frame_byte),
        .o_last_byte  (o_last_byte)
    );

endmodule
